@@ sv/sptm_pkg.sv @@
// shared types and constants of the sparse polynomial term merge adder
`default_nettype none

package sptm_pkg;

    localparam int COEF_W   = 32;
    localparam int EXPO_W   = 16;
    localparam int TERM_W   = COEF_W + EXPO_W;
    localparam int ACTION_W = 2;
    localparam int FLAGS_W  = 2;

    localparam logic [ACTION_W-1:0] ACT_LOAD_FIRST  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD_SECOND = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_START       = 2'd2;

    localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

    typedef struct packed {
        logic        [EXPO_W-1:0] exponent;
        logic signed [COEF_W-1:0] coefficient;
    } term_t;

    typedef enum logic {
        ST_IDLE,
        ST_MERGE
    } state_t;

endpackage

`default_nettype wire

@@ sv/sparse_poly_term_merge_add_core.sv @@
// top level of the sparse polynomial term merge adder
`default_nettype none

// Two term lists of up to TERM_CAPACITY (coefficient, exponent) terms are
// loaded one transaction per cycle while idle, each highest exponent first;
// a load into a full list is dropped and flagged on the next merge run. A
// start transaction walks both lists and emits one result term per cycle
// while the output is not stalled: equal exponents are summed with
// saturation, otherwise the larger exponent goes first, then leftovers
// follow. The merge works from the registered read of the two term
// memories, each read at one port. Both lists empty gives one item with
// term_valid low. The term memories hold no reset value and need no
// clearing pass; counts and the drop flag clear after every run.
module sparse_poly_term_merge_add_core #(
    parameter int TERM_CAPACITY = 32
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [47:0] s_tdata,   // coefficient[31:0], exponent[47:32]
    input  wire  [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [47:0] m_tdata,   // sum_coefficient[31:0], sum_exponent[47:32]
    output logic [1:0]  m_tuser,   // term_valid[0], dropped_loads[1]
    output logic        m_tlast
);

    localparam int AW    = (TERM_CAPACITY > 1) ? $clog2(TERM_CAPACITY) : 1;
    localparam int CNT_W = $clog2(TERM_CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(TERM_CAPACITY);

    sptm_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0] first_count_reg, first_count_next;
    logic [CNT_W-1:0] second_count_reg, second_count_next;
    logic             overflow_reg, overflow_next;
    logic [CNT_W-1:0] dp_reg, dp_next;
    logic [CNT_W-1:0] dq_reg, dq_next;

    logic                        m_tvalid_reg, m_tvalid_next;
    logic [sptm_pkg::TERM_W-1:0] m_tdata_reg;
    logic [sptm_pkg::FLAGS_W-1:0] m_tuser_reg;
    logic                        m_tlast_reg;

    logic        in_fire;
    logic        load_first, load_second, start;
    logic        first_full, second_full;
    logic        we_first, we_second;
    logic [AW-1:0] raddr_first, raddr_second;
    logic [sptm_pkg::TERM_W-1:0] rdata_first, rdata_second;
    sptm_pkg::term_t f_term, s_term;

    logic        out_free, step;
    logic        f_avail, s_avail;
    logic        take_f, take_s;
    logic        res_valid, res_last;
    logic signed [sptm_pkg::COEF_W-1:0] res_coef;
    logic        [sptm_pkg::EXPO_W-1:0] res_expo;
    logic        [sptm_pkg::COEF_W:0]   wide_sum;
    logic [CNT_W-1:0] dp_adv, dq_adv;

    // input decode
    assign in_fire = s_tvalid && s_tready;

    always_comb
    begin
        load_first  = 1'b0;
        load_second = 1'b0;
        start       = 1'b0;
        unique case (s_tuser)
            sptm_pkg::ACT_LOAD_FIRST:  load_first  = in_fire;
            sptm_pkg::ACT_LOAD_SECOND: load_second = in_fire;
            sptm_pkg::ACT_START:       start       = in_fire;
            default:                   ;
        endcase
    end

    assign first_full  = (first_count_reg == CAP_CNT);
    assign second_full = (second_count_reg == CAP_CNT);
    assign we_first    = load_first && !first_full;
    assign we_second   = load_second && !second_full;

    // term memories
    sptm_ram #(
        .WIDTH (sptm_pkg::TERM_W),
        .DEPTH (TERM_CAPACITY)
    ) u_first_ram (
        .clk   (clk),
        .we    (we_first),
        .waddr (first_count_reg[AW-1:0]),
        .wdata (s_tdata),
        .raddr (raddr_first),
        .rdata (rdata_first)
    );

    sptm_ram #(
        .WIDTH (sptm_pkg::TERM_W),
        .DEPTH (TERM_CAPACITY)
    ) u_second_ram (
        .clk   (clk),
        .we    (we_second),
        .waddr (second_count_reg[AW-1:0]),
        .wdata (s_tdata),
        .raddr (raddr_second),
        .rdata (rdata_second)
    );

    assign f_term = sptm_pkg::term_t'(rdata_first);
    assign s_term = sptm_pkg::term_t'(rdata_second);

    // merge step
    assign out_free = !m_tvalid_reg || m_tready;
    assign step     = (state_reg == sptm_pkg::ST_MERGE) && out_free;
    assign f_avail  = (dp_reg < first_count_reg);
    assign s_avail  = (dq_reg < second_count_reg);
    assign wide_sum = {f_term.coefficient[sptm_pkg::COEF_W-1], f_term.coefficient}
                    + {s_term.coefficient[sptm_pkg::COEF_W-1], s_term.coefficient};

    always_comb
    begin
        take_f   = 1'b0;
        take_s   = 1'b0;
        res_coef = '0;
        res_expo = '0;
        priority if (f_avail && s_avail && (f_term.exponent == s_term.exponent))
        begin
            take_f   = 1'b1;
            take_s   = 1'b1;
            res_expo = f_term.exponent;
            if (wide_sum[sptm_pkg::COEF_W] != wide_sum[sptm_pkg::COEF_W-1])
            begin
                res_coef = wide_sum[sptm_pkg::COEF_W] ? sptm_pkg::COEF_MIN
                                                      : sptm_pkg::COEF_MAX;
            end
            else
            begin
                res_coef = wide_sum[sptm_pkg::COEF_W-1:0];
            end
        end
        else if (f_avail && (!s_avail || (f_term.exponent > s_term.exponent)))
        begin
            take_f   = 1'b1;
            res_coef = f_term.coefficient;
            res_expo = f_term.exponent;
        end
        else if (s_avail)
        begin
            take_s   = 1'b1;
            res_coef = s_term.coefficient;
            res_expo = s_term.exponent;
        end
        else
        begin
            res_coef = '0;
            res_expo = '0;
        end
    end

    assign res_valid = take_f || take_s;
    assign dp_adv    = dp_reg + CNT_W'(take_f);
    assign dq_adv    = dq_reg + CNT_W'(take_s);
    assign res_last  = (dp_adv == first_count_reg) && (dq_adv == second_count_reg);

    // read addresses come from the next pointer values, so the registered memory data matches the current pointers
    always_comb
    begin
        dp_next = dp_reg;
        dq_next = dq_reg;
        if (step)
        begin
            dp_next = res_last ? '0 : dp_adv;
            dq_next = res_last ? '0 : dq_adv;
        end
    end

    assign raddr_first  = (dp_next == CAP_CNT) ? '0 : dp_next[AW-1:0];
    assign raddr_second = (dq_next == CAP_CNT) ? '0 : dq_next[AW-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sptm_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = sptm_pkg::ST_MERGE;
                end
            end
            sptm_pkg::ST_MERGE:
            begin
                if (step && res_last)
                begin
                    state_next = sptm_pkg::ST_IDLE;
                end
            end
            default: state_next = sptm_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        s_tready = 1'b0;
        unique case (state_reg)
            sptm_pkg::ST_IDLE:  s_tready = 1'b1;
            sptm_pkg::ST_MERGE: s_tready = 1'b0;
            default:            s_tready = 1'b0;
        endcase
    end

    // list bookkeeping
    always_comb
    begin
        first_count_next  = first_count_reg;
        second_count_next = second_count_reg;
        overflow_next     = overflow_reg;
        if (we_first)
        begin
            first_count_next = first_count_reg + CNT_W'(1);
        end
        if (we_second)
        begin
            second_count_next = second_count_reg + CNT_W'(1);
        end
        if ((load_first && first_full) || (load_second && second_full))
        begin
            overflow_next = 1'b1;
        end
        if (step && res_last)
        begin
            first_count_next  = '0;
            second_count_next = '0;
            overflow_next     = 1'b0;
        end
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (step)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= sptm_pkg::ST_IDLE;
            first_count_reg  <= '0;
            second_count_reg <= '0;
            overflow_reg     <= 1'b0;
            dp_reg           <= '0;
            dq_reg           <= '0;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            first_count_reg  <= first_count_next;
            second_count_reg <= second_count_next;
            overflow_reg     <= overflow_next;
            dp_reg           <= dp_next;
            dq_reg           <= dq_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            m_tdata_reg <= {res_expo, res_coef};
            m_tuser_reg <= {overflow_reg, res_valid};
            m_tlast_reg <= res_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTHESIS
    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (dp_reg <= first_count_reg) && (dq_reg <= second_count_reg))
        else $error("merge pointer ran past its list count");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> m_tlast)
        else $error("empty result transaction not marked last");

    a_run_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (step && res_last) |=> (first_count_reg == '0) && (second_count_reg == '0)
                               && !overflow_reg && (state_reg == sptm_pkg::ST_IDLE))
        else $error("list state not cleared after merge run");

    a_no_load_in_merge: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sptm_pkg::ST_MERGE) |=> $stable(first_count_reg)
                                              || (first_count_reg == '0))
        else $error("first list changed during merge run");
`endif

endmodule

`default_nettype wire

@@ sv/sptm_ram.sv @@
// generic single-port-write ram with registered read
`default_nettype none

module sptm_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  wire                                   clk,
    input  wire                                   we,
    input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire  [WIDTH-1:0]                      wdata,
    input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire
